[rtl/cpq_pkg.sv]
// Package for the two-class cut-payload descriptor queue.
// Item types, opcode and status codes, register indexes and reset values.
// No dependencies.
`default_nettype none

package cpq_pkg;

   localparam int TagFieldBits  = 16;
   localparam int SizeBits      = 14;
   localparam int LimitBits     = 24;
   localparam int WeightBits    = 8;
   localparam int CounterBits   = 9;
   localparam int CsrIndexBits  = 2;
   localparam int CsrDataBits   = 24;

   localparam int DefQueueDepth = 64;
   localparam int DefTagBits    = 16;

   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_DEQUEUE = 1'b1;

   localparam logic [1:0] ENQ_HIGH    = 2'd0;
   localparam logic [1:0] ENQ_LOW     = 2'd1;
   localparam logic [1:0] ENQ_CUT     = 2'd2;
   localparam logic [1:0] ENQ_DROPPED = 2'd3;

   localparam logic [CsrIndexBits-1:0] CSR_BYTE_LIMIT   = 2'd0;
   localparam logic [CsrIndexBits-1:0] CSR_HIGH_WEIGHT  = 2'd1;
   localparam logic [CsrIndexBits-1:0] CSR_LOW_WEIGHT   = 2'd2;
   localparam logic [CsrIndexBits-1:0] CSR_HEADER_BYTES = 2'd3;

   localparam logic [LimitBits-1:0]  RST_BYTE_LIMIT   = 24'd65536;
   localparam logic [WeightBits-1:0] RST_HIGH_WEIGHT  = 8'd1;
   localparam logic [WeightBits-1:0] RST_LOW_WEIGHT   = 8'd1;
   localparam logic [SizeBits-1:0]   RST_HEADER_BYTES = 14'd40;

   typedef struct packed {
      logic                    opcode;
      logic [TagFieldBits-1:0] pkt_tag;
      logic [SizeBits-1:0]     pkt_size;
      logic                    is_bulk;
      logic                    hdr_only;
   } req_type;

   typedef struct packed {
      logic [1:0]              enq_status;
      logic                    deq_valid;
      logic [TagFieldBits-1:0] deq_tag;
      logic [SizeBits-1:0]     deq_size;
      logic                    deq_header;
      logic                    deq_low_class;
   } rsp_type;

endpackage

`default_nettype wire

[rtl/cpq_fifo.sv]
// Descriptor FIFO for one class: memory, head pointer and fill count.
// Head entry is read ahead into a register, with bypass on a write to that slot.
// No package dependencies.
`default_nettype none

module cpq_fifo #(
   parameter int DEPTH     = 64,
   parameter int DATA_BITS = 31
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push_valid,
   input  wire logic [DATA_BITS-1:0] push_data,
   input  wire logic                 pop_valid,
   output logic      [DATA_BITS-1:0] head_data,
   output logic                      empty,
   output logic                      full
);

   localparam int AddrBits  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CountBits = $clog2(DEPTH + 1);
   localparam int SumBits   = AddrBits + 1;

   logic [DATA_BITS-1:0] mem_ff [DEPTH];
   logic [DATA_BITS-1:0] head_data_ff;
   logic [AddrBits-1:0]  head_ff, head_in;
   logic [CountBits-1:0] count_ff, count_in;
   logic [SumBits-1:0]   tail_sum;
   logic [AddrBits-1:0]  tail_addr;

   always_comb begin
      tail_sum = SumBits'(head_ff) + SumBits'(count_ff);
      if (tail_sum >= SumBits'(DEPTH)) begin
         tail_sum = tail_sum - SumBits'(DEPTH);
      end
      tail_addr = tail_sum[AddrBits-1:0];
   end

   always_comb begin
      head_in = head_ff;
      if (pop_valid) begin
         head_in = (head_ff == AddrBits'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
      end
      count_in = count_ff + CountBits'(push_valid) - CountBits'(pop_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         mem_ff[tail_addr] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid && tail_addr == head_in) begin
         head_data_ff <= push_data;
      end else begin
         head_data_ff <= mem_ff[head_in];
      end
   end

   assign head_data = head_data_ff;
   assign empty     = (count_ff == '0);
   assign full      = (count_ff == CountBits'(DEPTH));

endmodule

`default_nettype wire

[rtl/cpq_wrr.sv]
// Weighted round-robin class picker for the two-class queue.
// Holds the round counter and the last served class; uses cpq_pkg.
`default_nettype none

module cpq_wrr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           advance,
   input  wire logic [cpq_pkg::WeightBits-1:0] high_weight,
   input  wire logic [cpq_pkg::WeightBits-1:0] low_weight,
   output logic                                pick_low
);
   import cpq_pkg::*;

   logic [CounterBits-1:0] round_ff, round_in;
   logic [CounterBits-1:0] round_inc;
   logic [CounterBits-1:0] weight_sum;
   logic                   served_ff, served_in;

   always_comb begin
      round_inc  = round_ff + 1'b1;
      weight_sum = CounterBits'(high_weight) + CounterBits'(low_weight);
      round_in   = (round_inc >= weight_sum) ? '0 : round_inc;
      served_in  = !(round_in < CounterBits'(high_weight));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         round_ff  <= '0;
         served_ff <= 1'b0;
      end else if (advance) begin
         round_ff  <= round_in;
         served_ff <= served_in;
      end
   end

   assign pick_low = advance ? served_in : served_ff;

endmodule

`default_nettype wire

[rtl/cut_payload_two_class_queue_top.sv]
// Two-class cut-payload descriptor queue, top level; uses cpq_pkg, cpq_fifo, cpq_wrr.
// An accepted item passes through the input register and then the result register.
// Throughput: one enqueue or dequeue item per cycle while the result is not stalled;
// the result register and the lookahead read of each FIFO memory set that figure.
// Reset clears pointers, byte counts and the round counter, and sets the CSRs to defaults;
// FIFO memories are not cleared and need no clearing pass.
`default_nettype none

module cut_payload_two_class_queue_top #(
   parameter int QUEUE_DEPTH = cpq_pkg::DefQueueDepth,
   parameter int TAG_BITS    = cpq_pkg::DefTagBits
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire cpq_pkg::req_type                 req_item,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output cpq_pkg::rsp_type                      rsp_item,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [cpq_pkg::CsrIndexBits-1:0] csr_index,
   input  wire logic [cpq_pkg::CsrDataBits-1:0]  csr_data
);
   import cpq_pkg::*;

   localparam int StoredTagBits = (TAG_BITS < TagFieldBits) ? TAG_BITS : TagFieldBits;
   localparam int EntryBits     = StoredTagBits + SizeBits + 1;
   localparam int SumBits       = LimitBits + 1;

   logic [LimitBits-1:0]  byte_limit_ff;
   logic [WeightBits-1:0] high_weight_ff, low_weight_ff;
   logic [SizeBits-1:0]   header_bytes_ff;

   req_type               in_ff;
   logic                  in_valid_ff;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff;
   logic                  advance, process;

   logic [LimitBits-1:0]  high_bytes_ff, high_bytes_in;
   logic [LimitBits-1:0]  low_bytes_ff, low_bytes_in;

   logic                  high_push, low_push, high_pop, low_pop;
   logic [EntryBits-1:0]  push_entry, high_head, low_head, deq_entry;
   logic                  high_empty, high_full, low_empty, low_full;
   logic                  wrr_advance, wrr_pick_low;

   logic                  is_enq, is_deq;
   logic                  want_low, low_over, cut, go_low, drop;
   logic [SumBits-1:0]    low_sum, tgt_sum;
   logic [SizeBits-1:0]   enq_size, deq_size;
   logic                  enq_hdr;
   logic                  both_busy, any_busy, deq_low;
   logic [LimitBits-1:0]  deq_bytes, deq_bytes_left;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_limit_ff   <= RST_BYTE_LIMIT;
         high_weight_ff  <= RST_HIGH_WEIGHT;
         low_weight_ff   <= RST_LOW_WEIGHT;
         header_bytes_ff <= RST_HEADER_BYTES;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_BYTE_LIMIT:   byte_limit_ff   <= csr_data[LimitBits-1:0];
            CSR_HIGH_WEIGHT:  high_weight_ff  <= csr_data[WeightBits-1:0];
            CSR_LOW_WEIGHT:   low_weight_ff   <= csr_data[WeightBits-1:0];
            CSR_HEADER_BYTES: header_bytes_ff <= csr_data[SizeBits-1:0];
            default:          byte_limit_ff   <= byte_limit_ff;
         endcase
      end
   end

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign process   = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_valid_ff <= 1'b1;
      end else if (process) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_ff <= req_item;
      end
   end

   // enqueue: classify, cut on low overflow, then admit or drop
   always_comb begin
      is_enq   = (in_ff.opcode == OP_ENQUEUE);
      is_deq   = (in_ff.opcode == OP_DEQUEUE);
      want_low = in_ff.is_bulk && !in_ff.hdr_only;
      low_sum  = SumBits'(low_bytes_ff) + SumBits'(in_ff.pkt_size);
      low_over = (low_sum > SumBits'(byte_limit_ff));
      cut      = want_low && low_over;
      go_low   = want_low && !low_over;
      enq_size = cut ? header_bytes_ff : in_ff.pkt_size;
      enq_hdr  = cut || in_ff.hdr_only;
      tgt_sum  = (go_low ? SumBits'(low_bytes_ff) : SumBits'(high_bytes_ff))
                 + SumBits'(enq_size);
      drop     = (tgt_sum > SumBits'(byte_limit_ff)) || (go_low ? low_full : high_full);
      push_entry = {enq_hdr, enq_size, in_ff.pkt_tag[StoredTagBits-1:0]};
   end

   // dequeue: pick a class, pop its head
   always_comb begin
      both_busy   = !high_empty && !low_empty;
      any_busy    = !high_empty || !low_empty;
      wrr_advance = process && is_deq && both_busy;
      deq_low     = both_busy ? wrr_pick_low : high_empty;
      deq_entry   = deq_low ? low_head : high_head;
      deq_size    = deq_entry[StoredTagBits +: SizeBits];
      deq_bytes   = deq_low ? low_bytes_ff : high_bytes_ff;
      deq_bytes_left = (deq_bytes >= LimitBits'(deq_size))
                       ? deq_bytes - LimitBits'(deq_size) : '0;
   end

   assign high_push = process && is_enq && !drop && !go_low;
   assign low_push  = process && is_enq && !drop && go_low;
   assign high_pop  = process && is_deq && any_busy && !deq_low;
   assign low_pop   = process && is_deq && any_busy && deq_low;

   always_comb begin
      high_bytes_in = high_bytes_ff;
      low_bytes_in  = low_bytes_ff;
      if (high_push) begin
         high_bytes_in = tgt_sum[LimitBits-1:0];
      end
      if (low_push) begin
         low_bytes_in = tgt_sum[LimitBits-1:0];
      end
      if (high_pop) begin
         high_bytes_in = deq_bytes_left;
      end
      if (low_pop) begin
         low_bytes_in = deq_bytes_left;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_bytes_ff <= '0;
         low_bytes_ff  <= '0;
      end else begin
         high_bytes_ff <= high_bytes_in;
         low_bytes_ff  <= low_bytes_in;
      end
   end

   always_comb begin
      rsp_in = '0;
      if (is_enq) begin
         priority if (drop) begin
            rsp_in.enq_status = ENQ_DROPPED;
         end else if (go_low) begin
            rsp_in.enq_status = ENQ_LOW;
         end else if (cut) begin
            rsp_in.enq_status = ENQ_CUT;
         end else begin
            rsp_in.enq_status = ENQ_HIGH;
         end
      end else if (any_busy) begin
         rsp_in.deq_valid     = 1'b1;
         rsp_in.deq_tag       = TagFieldBits'(deq_entry[StoredTagBits-1:0]);
         rsp_in.deq_size      = deq_size;
         rsp_in.deq_header    = deq_entry[EntryBits-1];
         rsp_in.deq_low_class = deq_low;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (process) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (process) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   cpq_fifo #(
      .DEPTH     (QUEUE_DEPTH),
      .DATA_BITS (EntryBits)
   ) u_high_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (high_push),
      .push_data  (push_entry),
      .pop_valid  (high_pop),
      .head_data  (high_head),
      .empty      (high_empty),
      .full       (high_full)
   );

   cpq_fifo #(
      .DEPTH     (QUEUE_DEPTH),
      .DATA_BITS (EntryBits)
   ) u_low_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (low_push),
      .push_data  (push_entry),
      .pop_valid  (low_pop),
      .head_data  (low_head),
      .empty      (low_empty),
      .full       (low_full)
   );

   cpq_wrr u_wrr (
      .clock       (clock),
      .reset       (reset),
      .advance     (wrr_advance),
      .high_weight (high_weight_ff),
      .low_weight  (low_weight_ff),
      .pick_low    (wrr_pick_low)
   );

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      (high_push |-> !high_full) and (low_push |-> !low_full))
      else $error("push into a full class FIFO");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      (high_pop |-> !high_empty) and (low_pop |-> !low_empty))
      else $error("pop from an empty class FIFO");

   a_one_fifo_op: assert property (@(posedge clock) disable iff (reset)
      $countones({high_push, low_push, high_pop, low_pop}) <= 1)
      else $error("more than one FIFO operation in a cycle");

   a_deq_status_clear: assert property (@(posedge clock) disable iff (reset)
      process && is_deq |=> rsp_ff.enq_status == ENQ_HIGH)
      else $error("dequeue result carries an enqueue status");

endmodule

`default_nettype wire
